@@ sv/b64_pkg.sv @@
`timescale 1ns / 1ps

package b64_pkg;

   // Group queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] PAD_CHAR   = 8'h3D; // '='
   localparam logic [7:0] PLUS_CHAR  = 8'h2B; // '+'
   localparam logic [7:0] SLASH_CHAR = 8'h2F; // '/'
   localparam logic [7:0] UPPER_A    = 8'h41;
   localparam logic [7:0] LOWER_A    = 8'h61;
   localparam logic [7:0] DIGIT_0    = 8'h30;

   // One three-byte group ready for encoding; missing bytes are zero
   typedef struct packed {
      logic [23:0] data;
      logic [1:0]  pad;   // number of '=' chars, 0..2
      logic        last;  // group closes the message
   } grp_type;

   typedef struct packed {
      logic    push;
      grp_type grp;
   } grp_push_type;

   typedef struct packed {
      logic    empty;
      logic    full;
      grp_type head;
   } grp_status_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] w;
      begin
         w = {2'b00, v};
         if (v < 6'd26) begin
            return UPPER_A + w;
         end else if (v < 6'd52) begin
            return LOWER_A + w - 8'd26;
         end else if (v < 6'd62) begin
            return DIGIT_0 + w - 8'd52;
         end else if (v == 6'd62) begin
            return PLUS_CHAR;
         end else begin
            return SLASH_CHAR;
         end
      end
   endfunction

endpackage

@@ sv/base64_stream_encoder.sv @@
`timescale 1ns / 1ps
// A request that closes a group is written into the group queue; the back then
// loads its first char into the output register, and the other three follow
// one per cycle while rsp_pop is high. Throughput is one char per cycle while
// the sink pops, set by the single-char output register.
// Reset: synchronous, active high; clears byte count, queue and output valid.

module base64_stream_encoder (
   input  logic       clock,
   input  logic       reset,
   // request side
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_msg_last,
   // response side
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_group_end,
   output logic       rsp_msg_end
);
   import b64_pkg::*;

   grp_push_type   q_push;
   grp_status_type q_status;
   logic           q_pop;

   // Front: gathers request bytes into groups of three, closes short
   // groups on the final byte and records the pad count.
   b64_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_in_byte  (req_in_byte),
      .req_msg_last (req_msg_last),
      .q_full       (q_status.full),
      .q_push       (q_push)
   );

   // Two-entry group queue lets the front keep taking bytes while the
   // back is still streaming out the previous group.
   b64_grp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .q_pop    (q_pop),
      .q_status (q_status)
   );

   // Back: walks the head group one sextet per cycle into the output
   // register whenever it is free; it frees up on the same edge it is popped.
   b64_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_pop         (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_out_char  (rsp_out_char),
      .rsp_group_end (rsp_group_end),
      .rsp_msg_end   (rsp_msg_end)
   );

   // Backpressure only when the group queue is full.
   assign req_full = q_status.full;

endmodule

@@ sv/b64_front.sv @@
`timescale 1ns / 1ps

module b64_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   input  logic [7:0]              req_in_byte,
   input  logic                    req_msg_last,
   input  logic                    q_full,
   output b64_pkg::grp_push_type   q_push
);
   import b64_pkg::*;

   logic [1:0] count_ff, count_in;
   logic [7:0] hold_ff [2];
   logic [7:0] b0, b1, b2;
   logic       accept, close;

   assign accept = req_push & ~q_full;
   // count never reaches 3; bit 1 set means two bytes held
   assign close  = accept & (count_ff[1] | req_msg_last);

   always_comb begin
      case (count_ff)
         2'd0: begin
            b0 = req_in_byte; b1 = 8'd0;       b2 = 8'd0;
         end
         2'd1: begin
            b0 = hold_ff[0];  b1 = req_in_byte; b2 = 8'd0;
         end
         default: begin
            b0 = hold_ff[0];  b1 = hold_ff[1]; b2 = req_in_byte;
         end
      endcase
   end

   always_comb begin
      q_push.push      = close;
      q_push.grp.data  = {b0, b1, b2};
      q_push.grp.last  = req_msg_last;
      case (count_ff)
         2'd0:    q_push.grp.pad = 2'd2;
         2'd1:    q_push.grp.pad = 2'd1;
         default: q_push.grp.pad = 2'd0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (close) begin
         count_in = 2'd0;
      end else if (accept) begin
         count_in = count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept & ~close) begin
         hold_ff[count_ff[0]] <= req_in_byte;
      end
   end

endmodule

@@ sv/b64_grp_queue.sv @@
`timescale 1ns / 1ps

module b64_grp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  b64_pkg::grp_push_type    q_push,
   input  logic                     q_pop,
   output b64_pkg::grp_status_type  q_status
);
   import b64_pkg::*;

   grp_type           ent_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign q_status.empty = (cnt_ff == '0);
   assign q_status.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.head  = ent_ff[rd_ptr_ff];

   assign do_push = q_push.push & ~q_status.full;
   assign do_pop  = q_pop & ~q_status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= q_push.grp;
      end
   end

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("group queue count out of range");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 || cnt_ff == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("group queue pointers disagree with count");
`endif

endmodule

@@ sv/b64_back.sv @@
`timescale 1ns / 1ps

module b64_back (
   input  logic                     clock,
   input  logic                     reset,
   input  b64_pkg::grp_status_type  q_status,
   output logic                     q_pop,
   input  logic                     rsp_pop,
   output logic                     rsp_empty,
   output logic [7:0]               rsp_out_char,
   output logic                     rsp_group_end,
   output logic                     rsp_msg_end
);
   import b64_pkg::*;

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] char_ff, char_in;
   logic       gend_ff, gend_in;
   logic       mend_ff, mend_in;
   logic       load;
   logic [5:0] sextet;
   logic [2:0] pad_sum;

   assign load  = ~q_status.empty & (~valid_ff | rsp_pop);
   assign q_pop = load & (idx_ff == 2'd3);

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = q_status.head.data[23:18];
         2'd1:    sextet = q_status.head.data[17:12];
         2'd2:    sextet = q_status.head.data[11:6];
         default: sextet = q_status.head.data[5:0];
      endcase
   end

   // char k is padding when k + pad reaches 4
   assign pad_sum = {1'b0, idx_ff} + {1'b0, q_status.head.pad};

   always_comb begin
      char_in  = char_ff;
      gend_in  = gend_ff;
      mend_in  = mend_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff & ~rsp_pop;
      if (load) begin
         char_in  = pad_sum[2] ? PAD_CHAR : sextet_char(sextet);
         gend_in  = (idx_ff == 2'd3);
         mend_in  = (idx_ff == 2'd3) & q_status.head.last;
         idx_in   = idx_ff + 2'd1;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      gend_ff <= gend_in;
      mend_ff <= mend_in;
   end

   assign rsp_empty     = ~valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_group_end = gend_ff;
   assign rsp_msg_end   = mend_ff;

`ifndef ASSERT_OFF
   a_group_held: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != 2'd0) |-> !q_status.empty)
      else $error("group left queue before all four chars went out");

   a_msg_end_on_group_end: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && mend_ff) |-> gend_ff)
      else $error("message end off a group boundary");
`endif

endmodule

@@ tb/tb_base64_stream_encoder.sv @@
`timescale 1ns / 1ps

module tb_base64_stream_encoder;
   import b64_pkg::*;

   // Stall limit: cycles with no request and no char accepted on either side
   localparam int STALL_LIMIT = 4000;
   // Quiet cycles after the last expected char, to catch stray output
   localparam int DRAIN_CYCLES = 12;

   // Own alphabet table, indexed by the 6-bit value
   localparam string B64_ALPHABET = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                                     "abcdefghijklmnopqrstuvwxyz0123456789+/"};

   typedef struct packed {
      logic [7:0] ch;
      logic       grp_end;
      logic       msg_end;
   } enc_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_msg_last = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_group_end;
   logic       rsp_msg_end;

   // Encoder mirror: bytes of the open group and how many are held
   logic [7:0]    held_data [2];
   logic [1:0]    held_cnt = 2'd0;
   enc_char_type  expected_chars [$];

   int  mismatches = 0;
   bit  idle_en = 1'b0;       // random gaps on both sides when set
   int  pop_gap_left = 0;
   int  stall_cycles = 0;

   base64_stream_encoder i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_in_byte   (req_in_byte),
      .req_msg_last  (req_msg_last),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_char  (rsp_out_char),
      .rsp_group_end (rsp_group_end),
      .rsp_msg_end   (rsp_msg_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mirror one accepted request. Bytes collect until a group of three fills
   // or the final byte arrives; then four chars are due, '=' filling the
   // places past the data chars (n bytes give n+1 data chars).
   task automatic encode_expect(input logic [7:0] b, input logic last);
      logic [23:0]  grp;
      logic [5:0]   sextet;
      int           n;
      enc_char_type c;
      if (held_cnt < 2'd2 && !last) begin
         held_data[held_cnt[0]] = b;
         held_cnt = held_cnt + 2'd1;
      end else begin
         n = held_cnt + 1;
         case (held_cnt)
            2'd0:    grp = {b, 16'h0000};
            2'd1:    grp = {held_data[0], b, 8'h00};
            default: grp = {held_data[0], held_data[1], b};
         endcase
         for (int k = 0; k < 4; k++) begin
            sextet    = grp[23 - 6 * k -: 6];
            c.ch      = (k > n) ? PAD_CHAR : B64_ALPHABET[sextet];
            c.grp_end = (k == 3);
            c.msg_end = (k == 3) && last;
            expected_chars.push_back(c);
         end
         held_cnt = 2'd0;
      end
   endtask

   task automatic record_mismatch(input string what, input enc_char_type exp_c,
                                  input enc_char_type act_c);
      mismatches++;
      if (mismatches <= 10)
         $display({"%0t: %0s: expected char %02h grp_end %b msg_end %b, ",
                   "got char %02h grp_end %b msg_end %b"},
                  $realtime, what, exp_c.ch, exp_c.grp_end, exp_c.msg_end,
                  act_c.ch, act_c.grp_end, act_c.msg_end);
   endtask

   // One request. Entered and left at a rising edge; push stays high between
   // back-to-back requests and only drops for a gap.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (idle_en && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push     <= 1'b1;
      req_in_byte  <= b;
      req_msg_last <= last;
      do @(posedge clock); while (req_full !== 1'b0);
      encode_expect(b, last);
   endtask

   // Random message, mostly short; bytes lean toward the extremes at times
   task automatic send_random_message(output int len);
      logic [7:0] b;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 7);
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
         endcase
         send_byte(b, i == len - 1);
      end
   endtask

   // Pad counts, full groups with and without the final flag, a group that
   // fills before the final byte, and the '+' and '/' ends of the alphabet
   task automatic test_directed();
      idle_en = 1'b0;
      send_byte(8'h00, 1'b1);   // lone byte, two pads
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);   // two bytes, one pad
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);   // full group closed by the final byte
      send_byte(8'h00, 1'b0);
      send_byte(8'hFB, 1'b1);
      send_byte(8'h4D, 1'b0);   // full group, message goes on
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b0);
      send_byte(8'hF8, 1'b1);   // then a short final group
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFE, 1'b0);
      send_byte(8'hFD, 1'b1);
   endtask

   task automatic test_random_idle();
      int sent;
      int len;
      idle_en = 1'b1;
      sent = 0;
      while (sent < 230) begin
         send_random_message(len);
         sent += len;
      end
   endtask

   task automatic test_random_steady();
      int sent;
      int len;
      idle_en = 1'b0;
      sent = 0;
      while (sent < 50) begin
         send_random_message(len);
         sent += len;
      end
   endtask

   // Sink side: pop high except for random stall bursts while idle_en is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop      <= 1'b0;
         pop_gap_left <= 0;
      end else if (pop_gap_left != 0) begin
         pop_gap_left <= pop_gap_left - 1;
         rsp_pop      <= 1'b0;
      end else if (idle_en && $urandom_range(0, 15) == 0) begin
         pop_gap_left <= $urandom_range(0, 11);
         rsp_pop      <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Every accepted char is matched against the oldest expected one
   always @(posedge clock) begin
      enc_char_type act_c;
      enc_char_type exp_c;
      if (!reset && rsp_pop === 1'b1 && rsp_empty === 1'b0) begin
         act_c = '{rsp_out_char, rsp_group_end, rsp_msg_end};
         if (expected_chars.size() == 0) begin
            record_mismatch("unexpected char", '0, act_c);
         end else begin
            exp_c = expected_chars.pop_front();
            if (act_c !== exp_c)
               record_mismatch("char mismatch", exp_c, act_c);
         end
      end
   end

   // Watchdog: too long without any traffic means the block is stuck
   always @(posedge clock) begin
      if (reset || (req_push && req_full === 1'b0) || (rsp_pop && rsp_empty === 1'b0)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_idle();
      test_random_steady();
      req_push <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (expected_chars.size() != 0)
         record_mismatch("missing char", expected_chars.pop_front(), '0);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/b64_pkg.sv
sv/b64_front.sv
sv/b64_grp_queue.sv
sv/b64_back.sv
sv/base64_stream_encoder.sv
tb/tb_base64_stream_encoder.sv
